// File: hw/rtl/smpq_pkg.sv
// shared types and codes for the sorted minimum-first priority queue
`default_nettype none

package smpq_pkg;

   localparam int KEY_W   = 32;
   localparam int OP_W    = 2;
   localparam int ERR_W   = 2;
   localparam int COUNT_W = 7;

   typedef logic signed [KEY_W-1:0] key_type;
   typedef logic [OP_W-1:0]         opcode_type;
   typedef logic [ERR_W-1:0]        error_type;

   // operation codes, code 3 behaves as a query
   localparam opcode_type OP_PUSH  = 2'd0;
   localparam opcode_type OP_POP   = 2'd1;
   localparam opcode_type OP_QUERY = 2'd2;

   // error codes
   localparam error_type ERR_NONE  = 2'd0;
   localparam error_type ERR_FULL  = 2'd1;
   localparam error_type ERR_EMPTY = 2'd2;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic    push_en;
      logic    pop_en;
      key_type key;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// File: hw/rtl/smpq_cell.sv
// one slot of the sorted chain: holds a key and trades it with its neighbors
`default_nettype none

module smpq_cell (
   input  wire logic                   clock,
   input  wire smpq_pkg::cell_ctrl_type ctrl,
   input  wire logic                   occupied,
   input  wire smpq_pkg::key_type      left_entry,
   input  wire logic                   left_ins,
   input  wire smpq_pkg::key_type      right_entry,
   output      smpq_pkg::key_type      entry,
   output      smpq_pkg::key_type      entry_next,
   output      logic                   ins
);
   import smpq_pkg::*;

   key_type entry_ff;
   key_type entry_in;

   // the new key belongs at or before this slot
   assign ins = !occupied || (ctrl.key <= entry_ff);

   // push shifts up from the left, pop shifts down from the right
   always_comb begin
      priority if (ctrl.push_en) begin
         if (ins) begin
            entry_in = left_ins ? left_entry : ctrl.key;
         end else begin
            entry_in = entry_ff;
         end
      end else if (ctrl.pop_en) begin
         entry_in = right_entry;
      end else begin
         entry_in = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry      = entry_ff;
   assign entry_next = entry_in;

endmodule

`default_nettype wire

// File: hw/rtl/sorted_min_priority_queue.sv
// Minimum-first priority queue of signed 32-bit keys held in ascending order in a
// row of DEPTH cells. Every cell compares the incoming key with its own entry in
// the same cycle and shifts toward its neighbor, so a new transaction can be accepted
// every cycle; the result of each transaction sits in an output register, and the next
// transaction is accepted while it waits as long as rsp_ready is high. Equal keys leave
// newest first. Push when full and pop when empty leave the queue unchanged and
// report an error.
`default_nettype none

module sorted_min_priority_queue #(
   parameter int DEPTH = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   input  wire smpq_pkg::opcode_type   req_opcode,
   input  wire smpq_pkg::key_type      req_key,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      smpq_pkg::key_type      rsp_front_key,
   output      logic                   rsp_is_empty,
   output      logic [smpq_pkg::COUNT_W-1:0] rsp_entry_count,
   output      smpq_pkg::error_type    rsp_error_code
);
   import smpq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   logic          req_fire;
   logic          is_full;
   logic          is_none;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   cell_ctrl_type ctrl;
   error_type     err;

   key_type       entry_q    [DEPTH];
   key_type       entry_nx_q [DEPTH];
   logic [DEPTH-1:0] ins_q;
   logic [DEPTH-1:0] occ_q;

   logic          rsp_valid_ff;
   key_type       rsp_front_key_ff;
   logic          rsp_is_empty_ff;
   logic [COUNT_W-1:0] rsp_entry_count_ff;
   error_type     rsp_error_code_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign is_full   = (count_ff == CW'(DEPTH));
   assign is_none   = (count_ff == '0);

   // decode the transaction
   always_comb begin
      ctrl.push_en = 1'b0;
      ctrl.pop_en  = 1'b0;
      ctrl.key     = req_key;
      err          = ERR_NONE;
      count_in     = count_ff;
      if (req_fire) begin
         unique case (req_opcode)
            OP_PUSH: begin
               if (is_full) begin
                  err = ERR_FULL;
               end else begin
                  ctrl.push_en = 1'b1;
                  count_in     = count_ff + CW'(1);
               end
            end
            OP_POP: begin
               if (is_none) begin
                  err = ERR_EMPTY;
               end else begin
                  ctrl.pop_en = 1'b1;
                  count_in    = count_ff - CW'(1);
               end
            end
            default: begin
               err = ERR_NONE;
            end
         endcase
      end
   end

   // chain of cells
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      key_type left_entry;
      logic    left_ins;
      key_type right_entry;

      assign occ_q[i] = (CW'(i) < count_ff);

      if (i == 0) begin : g_head
         assign left_entry = '0;
         assign left_ins   = 1'b0;
      end else begin : g_body
         assign left_entry = entry_q[i-1];
         assign left_ins   = ins_q[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_entry = entry_q[i];
      end else begin : g_mid
         assign right_entry = entry_q[i+1];
      end

      smpq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (occ_q[i]),
         .left_entry  (left_entry),
         .left_ins    (left_ins),
         .right_entry (right_entry),
         .entry       (entry_q[i]),
         .entry_next  (entry_nx_q[i]),
         .ins         (ins_q[i])
      );
   end

   // count and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_front_key_ff   <= (count_in == '0) ? key_type'(0) : entry_nx_q[0];
         rsp_is_empty_ff    <= (count_in == '0);
         rsp_entry_count_ff <= COUNT_W'(count_in);
         rsp_error_code_ff  <= err;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_front_key   = rsp_front_key_ff;
   assign rsp_is_empty    = rsp_is_empty_ff;
   assign rsp_entry_count = rsp_entry_count_ff;
   assign rsp_error_code  = rsp_error_code_ff;

`ifndef NO_ASSERTIONS
   // a pending response always describes the current count
   a_empty_matches_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_is_empty_ff == (count_ff == '0)))
      else $error("empty flag disagrees with live count");

   // the count never passes the capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("live count above capacity");

   // a successful push grows the queue by one
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      ctrl.push_en |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("push did not grow the queue");

   // the two front cells stay in order
   a_front_sorted: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CW'(2)) |-> (entry_q[0] <= entry_q[1]))
      else $error("front entries out of order");
`endif

endmodule

`default_nettype wire

// File: test/sorted_min_priority_queue_tb.sv
// testbench for the sorted minimum-first priority queue: random and directed traffic, scoreboard
`timescale 1ns / 1ps

module sorted_min_priority_queue_tb;
   import smpq_pkg::*;

   localparam int QUEUE_DEPTH  = 64;
   localparam int TARGET_ITEMS = 1600;
   localparam int HOLD_CYCLES  = 150;
   localparam int QUIET_LIMIT  = 2000;

   // the fourth opcode value acts as a query
   localparam opcode_type OP_UNUSED = 2'd3;

   localparam key_type KEY_MAX = 32'sh7fff_ffff;
   localparam key_type KEY_MIN = 32'sh8000_0000;

   typedef struct packed {
      opcode_type opcode;
      key_type    key;
   } request_type;

   typedef struct packed {
      key_type              front_key;
      logic                 is_empty;
      logic [COUNT_W-1:0]   entry_count;
      error_type            error_code;
   } queue_status_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   opcode_type           req_opcode = OP_QUERY;
   key_type              req_key = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   key_type              rsp_front_key;
   logic                 rsp_is_empty;
   logic [COUNT_W-1:0]   rsp_entry_count;
   error_type            rsp_error_code;

   // stimulus bookkeeping
   request_type          request_q[$];
   queue_status_type     pending_status_q[$];
   key_type              live_keys[$];
   int                   error_count = 0;
   int                   issued = 0;
   int                   gen_count = 0;
   logic                 eager_mode = 1'b0;
   int                   hold_requests = 0;
   int                   holds_done = 0;
   logic                 req_taken = 1'b0;
   logic                 rsp_taken = 1'b0;
   int                   send_wait = 0;
   int                   recv_wait = 0;
   int                   hold_left = 0;
   int                   quiet_cycles = 0;

   sorted_min_priority_queue #(.DEPTH(QUEUE_DEPTH)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_front_key   (rsp_front_key),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_entry_count (rsp_entry_count),
      .rsp_error_code  (rsp_error_code)
   );

   always #6 clock = ~clock;

   // apply one operation to the sorted key list and describe the queue afterwards
   function automatic queue_status_type predict_status(opcode_type op, key_type key);
      queue_status_type status;
      int               pos;
      status.error_code = ERR_NONE;
      if (op == OP_PUSH) begin
         if (live_keys.size() >= QUEUE_DEPTH) begin
            status.error_code = ERR_FULL;
         end else begin
            // newest of equal keys goes in front
            pos = 0;
            while (pos < live_keys.size() && key > live_keys[pos])
               pos++;
            live_keys.insert(pos, key);
         end
      end else if (op == OP_POP) begin
         if (live_keys.size() == 0)
            status.error_code = ERR_EMPTY;
         else
            void'(live_keys.pop_front());
      end
      status.front_key   = (live_keys.size() > 0) ? live_keys[0] : '0;
      status.is_empty    = (live_keys.size() == 0);
      status.entry_count = COUNT_W'(live_keys.size());
      return status;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   function automatic int idle_draw();
      return eager_mode ? 0 : $urandom_range(0, 14);
   endfunction

   // mix of near-zero keys for ties, extremes and full-range values
   function automatic key_type pick_key();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 3)
         return key_type'(int'($urandom_range(0, 12)) - 6);
      else if (pick == 3)
         case ($urandom_range(0, 4))
            0: return KEY_MAX;
            1: return KEY_MIN;
            2: return key_type'(-1);
            3: return key_type'(1);
            default: return '0;
         endcase
      else
         return key_type'($urandom);
   endfunction

   task automatic queue_request(opcode_type op, key_type key);
      request_type item;
      item.opcode = op;
      item.key    = key;
      request_q.push_back(item);
      issued++;
      if (op == OP_PUSH && gen_count < QUEUE_DEPTH)
         gen_count++;
      else if (op == OP_POP && gen_count > 0)
         gen_count--;
   endtask

   task automatic wait_idle();
      while (request_q.size() > 0 || req_valid || pending_status_q.size() > 0)
         @(posedge clock);
   endtask

   // request driver, one transaction at a time with a random gap after each outside eager mode
   always @(negedge clock) begin : drive_requests
      request_type next_item;
      logic        next_valid;
      next_valid = req_valid;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_valid && req_taken) begin
            next_valid = 1'b0;
            send_wait  = idle_draw();
         end
         if (!next_valid) begin
            if (send_wait > 0) begin
               send_wait--;
            end else if (request_q.size() > 0) begin
               next_item  = request_q.pop_front();
               next_valid = 1'b1;
               req_opcode <= next_item.opcode;
               req_key    <= next_item.key;
            end
         end
      end
      req_valid <= next_valid;
   end

   // result receiver, random stall per transaction outside eager mode plus an occasional long hold
   always @(negedge clock) begin : drive_ready
      logic next_ready;
      if (reset) begin
         next_ready = 1'b0;
      end else begin
         if (rsp_taken)
            recv_wait = idle_draw();
         if (holds_done != hold_requests) begin
            holds_done++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else if (recv_wait > 0) begin
            recv_wait--;
            next_ready = 1'b0;
         end else begin
            next_ready = 1'b1;
         end
      end
      rsp_ready <= next_ready;
   end

   // monitor: check results against the oldest prediction, predict accepted requests
   always @(posedge clock) begin : monitor
      queue_status_type want;
      req_taken <= !reset && req_valid && req_ready;
      rsp_taken <= !reset && rsp_valid && rsp_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_status_q.size() == 0) begin
               $display("%0t: unexpected result, front %0h count %0d error %0d",
                        $time, rsp_front_key, rsp_entry_count, rsp_error_code);
               error_count++;
            end else begin
               want = pending_status_q.pop_front();
               check_field("front_key", 32'(want.front_key), 32'(rsp_front_key));
               check_field("is_empty", 32'(want.is_empty), 32'(rsp_is_empty));
               check_field("entry_count", 32'(want.entry_count), 32'(rsp_entry_count));
               check_field("error_code", 32'(want.error_code), 32'(rsp_error_code));
            end
         end
         if (req_valid && req_ready)
            pending_status_q.push_back(predict_status(req_opcode, req_key));
      end
   end

   // watchdog on cycles with work outstanding but no transaction on either side
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (request_q.size() == 0 && !req_valid && pending_status_q.size() == 0)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_status_q.size());
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int unsigned pick;
      int          run_len;
      opcode_type  op;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty cases, extremes, ties, unused opcode, drain past empty
      queue_request(OP_QUERY, '0);
      queue_request(OP_POP, KEY_MAX);
      queue_request(OP_UNUSED, KEY_MIN);
      queue_request(OP_PUSH, KEY_MAX);
      queue_request(OP_PUSH, KEY_MIN);
      queue_request(OP_PUSH, '0);
      queue_request(OP_PUSH, key_type'(-1));
      queue_request(OP_PUSH, '0);
      queue_request(OP_PUSH, key_type'(1));
      queue_request(OP_PUSH, KEY_MIN);
      queue_request(OP_PUSH, 32'sh5555_5555);
      queue_request(OP_PUSH, 32'shaaaa_aaaa);
      queue_request(OP_QUERY, key_type'(-1));
      queue_request(OP_UNUSED, key_type'(-1));
      repeat (9) queue_request(OP_POP, key_type'($urandom));
      queue_request(OP_POP, '0);
      queue_request(OP_QUERY, '0);
      wait_idle();

      // back pressure: receiver holds off while the sender fills the queue past full
      eager_mode    = 1'b1;
      hold_requests = hold_requests + 1;
      while (gen_count < QUEUE_DEPTH)
         queue_request(OP_PUSH, pick_key());
      repeat (4) queue_request(OP_PUSH, pick_key());
      wait_idle();
      eager_mode = 1'b0;

      // random phases: mixed traffic, fill to full, drain to empty, idling toggles
      while (issued < TARGET_ITEMS) begin
         pick = $urandom_range(0, 7);
         if (pick < 4) begin
            run_len = $urandom_range(20, 60);
            repeat (run_len) begin
               case ($urandom_range(0, 99)) inside
                  [0:44]:  op = OP_PUSH;
                  [45:79]: op = OP_POP;
                  [80:89]: op = OP_QUERY;
                  default: op = OP_UNUSED;
               endcase
               queue_request(op, pick_key());
            end
         end else if (pick == 4 || pick == 5) begin
            while (gen_count < QUEUE_DEPTH)
               queue_request(OP_PUSH, pick_key());
            repeat ($urandom_range(1, 3)) queue_request(OP_PUSH, pick_key());
            queue_request(OP_QUERY, pick_key());
         end else if (pick == 6) begin
            while (gen_count > 0)
               queue_request(OP_POP, pick_key());
            repeat ($urandom_range(1, 2)) queue_request(OP_POP, pick_key());
         end else begin
            wait_idle();
            eager_mode = ~eager_mode;
            if (eager_mode && $urandom_range(0, 3) == 0)
               hold_requests = hold_requests + 1;
         end
      end

      wait_idle();
      repeat (20) @(posedge clock);
      if (error_count == 0 && pending_status_q.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: sorted_min_priority_queue.f
hw/rtl/smpq_pkg.sv
hw/rtl/smpq_cell.sv
hw/rtl/sorted_min_priority_queue.sv
test/sorted_min_priority_queue_tb.sv
